// File: sv/hd_pkg.sv
// Shared constants, types and helpers for the Hausdorff distance core.
package hd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PT_W       = 2 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int DIST_W     = SQ_W + 1;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_LOAD_A  = 2'd0;
    localparam t_opcode OP_LOAD_B  = 2'd1;
    localparam t_opcode OP_COMPUTE = 2'd2;
    localparam t_opcode OP_CLEAR   = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // sequencer -> distance unit controls
    typedef struct packed {
        logic start;    // new outer point: forget running minimum
        logic step_dx;  // square dx of the current Q point
        logic step_dy;  // square dy, queue the sum for compare
    } t_du_ctl;

    function automatic logic [DIFF_W-1:0] abs_diff(input t_coord a, input t_coord b);
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? -d : d;
        return m[DIFF_W-1:0];
    endfunction

endpackage

// File: sv/hd_in_if.sv
// Input item channel: opcode and point coordinates.
interface hd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;

    modport source (output valid, opcode, coord_x, coord_y, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, output ready);
endinterface

// File: sv/hd_out_if.sv
// Result item channel: realising indices, squared distance, empty flag.
interface hd_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  index_in_a;
    logic [9:0]  index_in_b;
    logic [32:0] dist_squared;
    logic        empty_flag;

    modport source (output valid, index_in_a, index_in_b, dist_squared, empty_flag,
                    input ready);
    modport sink   (input valid, index_in_a, index_in_b, dist_squared, empty_flag,
                    output ready);
endinterface

// File: sv/hd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/hd_dist_unit.sv
// Shared squarer, accumulator and running-minimum compare.
module hd_dist_unit import hd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_du_ctl           i_ctl,
    input  t_coord            i_px,
    input  t_coord            i_py,
    input  t_coord            i_qx,
    input  t_coord            i_qy,
    input  logic [IDX_W-1:0]  i_j,
    output logic [DIST_W-1:0] o_best,
    output logic [IDX_W-1:0]  o_best_j
);
    logic [DIFF_W-1:0] w_dx;
    logic [DIFF_W-1:0] w_op;
    logic [DIST_W-1:0] w_sum;
    logic [SQ_W-1:0]   r_prod;
    logic [SQ_W-1:0]   r_acc;
    logic [DIFF_W-1:0] r_dy;
    logic [IDX_W-1:0]  r_cj;
    logic [IDX_W-1:0]  r_pj;
    logic              r_pend;
    logic              r_first;
    logic [DIST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_j;

    assign w_dx  = abs_diff(i_px, i_qx);
    assign w_op  = i_ctl.step_dy ? r_dy : w_dx;   // one squarer, two uses
    assign w_sum = {1'b0, r_acc} + {1'b0, r_prod};

    always_ff @(posedge i_clk) begin
        r_prod <= w_op * w_op;
        if (i_ctl.step_dx) begin
            r_dy <= abs_diff(i_py, i_qy);
            r_cj <= i_j;
        end
        if (i_ctl.step_dy) begin
            r_acc <= r_prod;
            r_pj  <= r_cj;
        end
        if (r_pend && (r_first || (w_sum < r_best))) begin
            r_best   <= w_sum;
            r_best_j <= r_pj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_first <= 1'b1;
        end else begin
            r_pend <= i_ctl.step_dy;
            if (i_ctl.start) begin
                r_first <= 1'b1;
            end else if (r_pend) begin
                r_first <= 1'b0;
            end
        end
    end

    assign o_best   = r_best;
    assign o_best_j = r_best_j;
endmodule

// File: sv/symmetric_hausdorff_distance_core.sv
// Symmetric Hausdorff distance core: point store, sequencer and shared distance unit.
// Load and clear items leave the sequencer idle; the next item is accepted the following cycle.
// A compute item passes each point pair through the single squarer twice (dx then dy),
// once per search direction, with states RDP, LATP, LAST and OUTER per outer point.
// Empty set: compute goes straight to the final state to post the result; ready in idle.
// Synchronous active-low reset empties both sets and drops any pending result.
module symmetric_hausdorff_distance_core import hd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hd_in_if.sink    i_item,
    hd_out_if.source o_result
);
    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // accept items
    localparam logic [2:0] S_RDP   = 3'd1;  // address outer point
    localparam logic [2:0] S_LATP  = 3'd2;  // latch outer point, Q[0] on its way
    localparam logic [2:0] S_DX    = 3'd3;  // square dx of Q[j], address Q[j+1]
    localparam logic [2:0] S_DY    = 3'd4;  // square dy of Q[j]
    localparam logic [2:0] S_LAST  = 3'd5;  // last compare of the inner search
    localparam logic [2:0] S_OUTER = 3'd6;  // fold minimum into running maximum
    localparam logic [2:0] S_FIN   = 3'd7;  // pick direction, post result

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b;
    logic              r_dir;      // 0: A to B, 1: B to A
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic              r_empty;
    t_coord            r_px;
    t_coord            r_py;

    // running maximum of the current direction
    logic              r_ofirst;
    logic [DIST_W-1:0] r_dmax;
    logic [IDX_W-1:0]  r_from;
    logic [IDX_W-1:0]  r_to;
    // finished A-to-B result
    logic [DIST_W-1:0] r_ab_d;
    logic [IDX_W-1:0]  r_ab_from;
    logic [IDX_W-1:0]  r_ab_to;

    // output register
    logic              r_ovalid;
    logic [IDX_W-1:0]  r_oia;
    logic [IDX_W-1:0]  r_oib;
    logic [DIST_W-1:0] r_odist;
    logic              r_oempty;

    logic              w_in_acc;
    logic              w_we_a;
    logic              w_we_b;
    logic [PT_W-1:0]   w_wpt;
    logic [IDX_W-1:0]  w_ra_addr;
    logic [IDX_W-1:0]  w_rb_addr;
    logic [PT_W-1:0]   w_rd_a;
    logic [PT_W-1:0]   w_rd_b;
    logic [PT_W-1:0]   w_rd_p;
    logic [PT_W-1:0]   w_rd_q;
    logic [CNT_W-1:0]  w_np;
    logic [CNT_W-1:0]  w_nq;
    logic [CNT_W-1:0]  w_i_nx;
    t_du_ctl           w_ctl;
    logic [DIST_W-1:0] w_best;
    logic [IDX_W-1:0]  w_best_j;
    logic              w_upd;
    logic [DIST_W-1:0] w_nmax;
    logic [IDX_W-1:0]  w_nfrom;
    logic [IDX_W-1:0]  w_nto;
    logic              w_slot_free;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_in_acc     = i_item.valid && i_item.ready;
    assign w_wpt        = {i_item.coord_y[COORD_BITS-1:0], i_item.coord_x[COORD_BITS-1:0]};

    // loads past capacity are dropped
    assign w_we_a = w_in_acc && (i_item.opcode == OP_LOAD_A) && (r_cnt_a < CNT_W'(MAX_POINTS));
    assign w_we_b = w_in_acc && (i_item.opcode == OP_LOAD_B) && (r_cnt_b < CNT_W'(MAX_POINTS));

    // P is the outer set, Q the searched one; they swap with the direction
    assign w_ra_addr = r_dir ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];
    assign w_rb_addr = r_dir ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0];
    assign w_rd_p    = r_dir ? w_rd_b : w_rd_a;
    assign w_rd_q    = r_dir ? w_rd_a : w_rd_b;
    assign w_np      = r_dir ? r_cnt_b : r_cnt_a;
    assign w_nq      = r_dir ? r_cnt_a : r_cnt_b;
    assign w_i_nx    = r_i + CNT_W'(1);

    hd_ram #(.DEPTH(MAX_POINTS), .WIDTH(PT_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (w_wpt),
        .i_raddr (w_ra_addr),
        .o_rdata (w_rd_a)
    );

    hd_ram #(.DEPTH(MAX_POINTS), .WIDTH(PT_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (w_wpt),
        .i_raddr (w_rb_addr),
        .o_rdata (w_rd_b)
    );

    assign w_ctl.start   = (r_state == S_LATP);
    assign w_ctl.step_dx = (r_state == S_DX);
    assign w_ctl.step_dy = (r_state == S_DY);

    hd_dist_unit u_du (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_qx     (w_rd_q[COORD_BITS-1:0]),
        .i_qy     (w_rd_q[PT_W-1:COORD_BITS]),
        .i_j      (r_j[IDX_W-1:0]),
        .o_best   (w_best),
        .o_best_j (w_best_j)
    );

    // outer maximum: strict greater keeps the first maximum
    assign w_upd   = r_ofirst || (w_best > r_dmax);
    assign w_nmax  = w_upd ? w_best : r_dmax;
    assign w_nfrom = w_upd ? r_i[IDX_W-1:0] : r_from;
    assign w_nto   = w_upd ? w_best_j : r_to;

    assign w_slot_free = !r_ovalid || o_result.ready;

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_LATP) begin
            r_px <= w_rd_p[COORD_BITS-1:0];
            r_py <= w_rd_p[PT_W-1:COORD_BITS];
        end
        if (r_state == S_OUTER) begin
            r_dmax <= w_nmax;
            r_from <= w_nfrom;
            r_to   <= w_nto;
            if (!r_dir) begin
                r_ab_d    <= w_nmax;
                r_ab_from <= w_nfrom;
                r_ab_to   <= w_nto;
            end
        end
        if ((r_state == S_FIN) && w_slot_free) begin
            r_oempty <= r_empty;
            if (r_empty) begin
                r_oia   <= '0;
                r_oib   <= '0;
                r_odist <= '0;
            end else if (r_ab_d > r_dmax) begin
                r_oia   <= r_ab_from;
                r_oib   <= r_ab_to;
                r_odist <= r_ab_d;
            end else begin
                // tie goes to B-to-A: its target is the A index
                r_oia   <= r_to;
                r_oib   <= r_from;
                r_odist <= r_dmax;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_dir    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_empty  <= 1'b0;
            r_ofirst <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            // post from the final state, otherwise drop once taken
            if ((r_state == S_FIN) && w_slot_free) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_we_a) begin
                        r_cnt_a <= r_cnt_a + CNT_W'(1);
                    end
                    if (w_we_b) begin
                        r_cnt_b <= r_cnt_b + CNT_W'(1);
                    end
                    if (w_in_acc) begin
                        unique case (i_item.opcode)
                            OP_CLEAR: begin
                                r_cnt_a <= '0;
                                r_cnt_b <= '0;
                            end
                            OP_COMPUTE: begin
                                r_dir    <= 1'b0;
                                r_i      <= '0;
                                r_j      <= '0;
                                r_ofirst <= 1'b1;
                                r_empty  <= (r_cnt_a == '0) || (r_cnt_b == '0);
                                if ((r_cnt_a == '0) || (r_cnt_b == '0)) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_RDP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RDP: begin
                    r_state <= S_LATP;
                end
                S_LATP: begin
                    r_state <= S_DX;
                end
                S_DX: begin
                    r_j     <= r_j + CNT_W'(1);
                    r_state <= S_DY;
                end
                S_DY: begin
                    if (r_j == w_nq) begin
                        r_state <= S_LAST;
                    end else begin
                        r_state <= S_DX;
                    end
                end
                S_LAST: begin
                    r_state <= S_OUTER;
                end
                S_OUTER: begin
                    // maximum restarts only when the direction turns
                    r_ofirst <= (w_i_nx == w_np) && !r_dir;
                    r_j      <= '0;
                    if (w_i_nx == w_np) begin
                        if (!r_dir) begin
                            r_dir    <= 1'b1;
                            r_i      <= '0;
                            r_state  <= S_RDP;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_i     <= w_i_nx;
                        r_state <= S_RDP;
                    end
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid        = r_ovalid;
    assign o_result.index_in_a   = r_oia;
    assign o_result.index_in_b   = r_oib;
    assign o_result.dist_squared = r_odist;
    assign o_result.empty_flag   = r_oempty;

`ifndef NO_ASSERTIONS
    // a result is only ever posted from the final state
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_FIN))
        else $error("result posted outside final state");

    // fill counts never pass capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(MAX_POINTS)) && (r_cnt_b <= CNT_W'(MAX_POINTS)))
        else $error("set count beyond capacity");

    // empty result carries zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.empty_flag) |->
        ((o_result.dist_squared == '0) && (o_result.index_in_a == '0) &&
         (o_result.index_in_b == '0)))
        else $error("empty result with nonzero fields");

    // an accepted load into A with room grows the count by one
    a_load_a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_item.opcode == OP_LOAD_A) && (r_cnt_a < CNT_W'(MAX_POINTS)))
        |=> (r_cnt_a == ($past(r_cnt_a) + CNT_W'(1))))
        else $error("load into A did not advance count");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the symmetric Hausdorff distance core.
module tb;
    import hd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Clock, reset and the two item channels
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #1 i_clk = ~i_clk;

    hd_in_if  item_if ();
    hd_out_if res_if ();

    symmetric_hausdorff_distance_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if)
    );

    // One expected result: the pair that realises the distance, or the empty flag.
    typedef struct packed {
        logic [IDX_W-1:0]  idx_a;
        logic [IDX_W-1:0]  idx_b;
        logic [DIST_W-1:0] sq_d;
        logic              empty;
    } t_hd_expect;

    // How random coordinates are spread: whole range, a tight cluster that
    // forces ties, or hugging the two ends of the signed range.
    typedef enum int { SPREAD_FULL, SPREAD_TIGHT, SPREAD_EDGE } t_spread;

    // Long receiver hold-off used to back the core up into its input.
    localparam int HOLD_CYCLES = 400;
    // Quiet cycles after the last result before the verdict.
    localparam int DRAIN_CYCLES = 40;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of both point sets and their counts
    // ------------------------------------------------------------------
    t_coord held_a_x [MAX_POINTS];
    t_coord held_a_y [MAX_POINTS];
    t_coord held_b_x [MAX_POINTS];
    t_coord held_b_y [MAX_POINTS];
    int     held_a;
    int     held_b;

    t_hd_expect pending_hd [$];

    // Run statistics
    int n_items;
    int n_computes;
    int n_results;
    int n_empty;
    int n_dropped;
    int n_errors;

    // Sender burst state and receiver hold-off request
    int burst_left;
    int hold_request;
    int hold_left;
    int stall_mode;
    int stall_window;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint pair_dist(input t_coord px, input t_coord py,
                                         input t_coord qx, input t_coord qy);
        longint dx;
        longint dy;
        dx = longint'(px) - longint'(qx);
        dy = longint'(py) - longint'(qy);
        return dx * dx + dy * dy;
    endfunction

    // Directed distance: for each outer point its nearest inner point (first
    // minimum), then the outer point whose nearest is farthest (first maximum).
    function automatic void search_direction(input bit from_a, output int from_idx,
                                             output int to_idx, output longint far_dist);
        int     np;
        int     nq;
        int     i;
        int     j;
        int     near_j;
        longint d;
        longint near_d;
        np       = from_a ? held_a : held_b;
        nq       = from_a ? held_b : held_a;
        from_idx = 0;
        to_idx   = 0;
        far_dist = 0;
        for (i = 0; i < np; i++) begin
            near_d = 0;
            near_j = 0;
            for (j = 0; j < nq; j++) begin
                if (from_a)
                    d = pair_dist(held_a_x[i], held_a_y[i], held_b_x[j], held_b_y[j]);
                else
                    d = pair_dist(held_b_x[i], held_b_y[i], held_a_x[j], held_a_y[j]);
                if (j == 0 || d < near_d) begin
                    near_d = d;
                    near_j = j;
                end
            end
            if (i == 0 || near_d > far_dist) begin
                from_idx = i;
                to_idx   = near_j;
                far_dist = near_d;
            end
        end
    endfunction

    function automatic t_hd_expect predict_hausdorff();
        t_hd_expect r;
        int         ab_from;
        int         ab_to;
        int         ba_from;
        int         ba_to;
        longint     ab_d;
        longint     ba_d;
        r = '0;
        if (held_a == 0 || held_b == 0) begin
            r.empty = 1'b1;
            return r;
        end
        search_direction(1'b1, ab_from, ab_to, ab_d);
        search_direction(1'b0, ba_from, ba_to, ba_d);
        // a tie between the two directions goes to B-to-A
        if (ab_d > ba_d) begin
            r.idx_a = ab_from[IDX_W-1:0];
            r.idx_b = ab_to[IDX_W-1:0];
            r.sq_d  = ab_d[DIST_W-1:0];
        end else begin
            r.idx_a = ba_to[IDX_W-1:0];
            r.idx_b = ba_from[IDX_W-1:0];
            r.sq_d  = ba_d[DIST_W-1:0];
        end
        return r;
    endfunction

    // Update the predictor with one accepted item.
    function automatic void track_item(input t_opcode op, input t_coord x, input t_coord y);
        case (op)
            OP_LOAD_A: begin
                if (held_a < MAX_POINTS) begin
                    held_a_x[held_a] = x;
                    held_a_y[held_a] = y;
                    held_a++;
                end else begin
                    n_dropped++;
                end
            end
            OP_LOAD_B: begin
                if (held_b < MAX_POINTS) begin
                    held_b_x[held_b] = x;
                    held_b_y[held_b] = y;
                    held_b++;
                end else begin
                    n_dropped++;
                end
            end
            OP_CLEAR: begin
                held_a = 0;
                held_b = 0;
            end
            default: begin
                pending_hd.push_back(predict_hausdorff());
                n_computes++;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps between them.
    // Valid is only lowered when a real gap follows, so it never drops and
    // rises within one time step.
    // ------------------------------------------------------------------
    task automatic send_item(input t_opcode op, input t_coord x, input t_coord y);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_if.valid   <= 1'b1;
        item_if.opcode  <= op;
        item_if.coord_x <= x;
        item_if.coord_y <= y;
        do @(posedge i_clk); while (!item_if.ready);
        n_items++;
        track_item(op, x, y);
    endtask

    function automatic t_coord random_coord(input t_spread spread);
        case (spread)
            SPREAD_FULL:  return t_coord'($urandom);
            SPREAD_TIGHT: return t_coord'(int'($urandom_range(0, 6)) - 3);
            default: begin
                if ($urandom_range(0, 1))
                    return t_coord'(16'h8000 + 16'($urandom_range(0, 3)));
                return t_coord'(16'h7fff - 16'($urandom_range(0, 3)));
            end
        endcase
    endfunction

    // Mostly small sets; now and then an empty one or a medium one.
    function automatic int pick_set_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 6);
        return $urandom_range(7, 20);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes every window; a hold-off request makes
    // it refuse results for a long, counted stretch. Results are checked here.
    // ------------------------------------------------------------------
    task automatic check_result();
        t_hd_expect want;
        t_hd_expect got;
        got.idx_a = res_if.index_in_a;
        got.idx_b = res_if.index_in_b;
        got.sq_d  = res_if.dist_squared;
        got.empty = res_if.empty_flag;
        n_results++;
        if (pending_hd.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("ERROR: result with none expected: a=%0d b=%0d d=%0d empty=%0b",
                         got.idx_a, got.idx_b, got.sq_d, got.empty);
            return;
        end
        want = pending_hd.pop_front();
        if (want.empty)
            n_empty++;
        if (got.idx_a !== want.idx_a || got.idx_b !== want.idx_b ||
            got.sq_d !== want.sq_d || got.empty !== want.empty) begin
            n_errors++;
            if (n_errors <= 10)
                $display("ERROR: result %0d exp a=%0d b=%0d d=%0d empty=%0b",
                         n_results, want.idx_a, want.idx_b, want.sq_d, want.empty,
                         " got a=%0d b=%0d d=%0d empty=%0b",
                         got.idx_a, got.idx_b, got.sq_d, got.empty);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            check_result();

        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (stall_window == 0) begin
            stall_mode   = $urandom_range(0, 3);
            stall_window = $urandom_range(20, 120);
        end
        stall_window--;

        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       res_if.ready <= 1'b1;                          // no stalls
                1:       res_if.ready <= 1'($urandom_range(0, 1));      // coin flip
                2:       res_if.ready <= (stall_window % 4) == 0;       // one in four
                default: res_if.ready <= $urandom_range(0, 4) != 0;    // mostly ready
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Compute with both sets empty, then with only A, then with only B.
    task automatic test_empty_sets();
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
        send_item(OP_LOAD_A, 16'sd5, -16'sd7);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
        send_item(OP_CLEAR, 16'sd0, 16'sd0);
        send_item(OP_LOAD_B, -16'sd1, 16'sd1);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
    endtask

    // Opposite corners of the coordinate range give the largest distance.
    task automatic test_coord_extremes();
        send_item(OP_CLEAR, -16'sd1, -16'sd1);
        send_item(OP_LOAD_A, -16'sd32768, -16'sd32768);
        send_item(OP_LOAD_B, 16'sd32767, 16'sd32767);
        send_item(OP_COMPUTE, 16'sd32767, -16'sd32768);
        send_item(OP_LOAD_A, 16'sd32767, -16'sd32768);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
    endtask

    // All-zero distances, equal directions and a clear between loads.
    task automatic test_ties_and_clear();
        send_item(OP_CLEAR, 16'sd0, 16'sd0);
        send_item(OP_LOAD_A, 16'sd0, 16'sd0);
        send_item(OP_LOAD_A, 16'sd0, 16'sd0);
        send_item(OP_LOAD_B, 16'sd0, 16'sd0);
        send_item(OP_LOAD_B, 16'sd0, 16'sd0);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
        // same distance both ways, several equal nearest points
        send_item(OP_CLEAR, 16'sd0, 16'sd0);
        send_item(OP_LOAD_A, 16'sd0, 16'sd0);
        send_item(OP_LOAD_A, 16'sd10, 16'sd0);
        send_item(OP_LOAD_B, 16'sd5, 16'sd0);
        send_item(OP_LOAD_B, 16'sd5, 16'sd0);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
        // A-to-B strictly larger: extra far A point
        send_item(OP_LOAD_A, 16'sd40, 16'sd3);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
        // clear then reload: old points must be gone
        send_item(OP_CLEAR, 16'sd0, 16'sd0);
        send_item(OP_LOAD_B, -16'sd9, 16'sd2);
        send_item(OP_LOAD_A, 16'sd1, 16'sd1);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
    endtask

    // Fill one set to capacity with its farthest point last; one more load
    // beyond capacity must be dropped or it would take over the result.
    task automatic test_set_full(input bit fill_a);
        int     i;
        t_coord x;
        t_coord y;
        send_item(OP_CLEAR, 16'sd0, 16'sd0);
        send_item(fill_a ? OP_LOAD_B : OP_LOAD_A, 16'sd0, 16'sd0);
        send_item(fill_a ? OP_LOAD_B : OP_LOAD_A, 16'sd1, 16'sd1);
        for (i = 0; i < MAX_POINTS; i++) begin
            x = t_coord'(int'($urandom_range(0, 100)) - 50);
            y = t_coord'(int'($urandom_range(0, 100)) - 50);
            if (i == MAX_POINTS - 1) begin
                x = 16'sd2000;
                y = -16'sd2000;
            end
            send_item(fill_a ? OP_LOAD_A : OP_LOAD_B, x, y);
        end
        send_item(fill_a ? OP_LOAD_A : OP_LOAD_B, -16'sd30000, 16'sd30000);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
        send_item(OP_CLEAR, 16'sd0, 16'sd0);
    endtask

    // Receiver holds off while the sender keeps offering items; the core
    // must stall its input until the result drains.
    task automatic test_backpressure();
        int i;
        send_item(OP_CLEAR, 16'sd0, 16'sd0);
        for (i = 0; i < 3; i++) begin
            send_item(OP_LOAD_A, random_coord(SPREAD_FULL), random_coord(SPREAD_FULL));
            send_item(OP_LOAD_B, random_coord(SPREAD_FULL), random_coord(SPREAD_FULL));
        end
        hold_request = HOLD_CYCLES;
        burst_left   = 50;
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
        send_item(OP_LOAD_A, random_coord(SPREAD_TIGHT), random_coord(SPREAD_TIGHT));
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
        send_item(OP_COMPUTE, 16'sd0, 16'sd0);
    endtask

    // ------------------------------------------------------------------
    // Random part: mostly clear / load / compute sequences with random
    // content, the rest raw noise that also appends to or breaks sets.
    // ------------------------------------------------------------------
    task automatic test_random_sequences();
        int      items_start;
        int      computes_start;
        int      na;
        int      nb;
        int      extra;
        t_spread spread;
        items_start    = n_items;
        computes_start = n_computes;
        while (n_items - items_start < 400 || n_computes - computes_start < 60) begin
            if ($urandom_range(0, 9) < 8 || held_a + held_b > 30) begin
                na     = pick_set_size();
                nb     = pick_set_size();
                spread = t_spread'($urandom_range(0, 2));
                send_item(OP_CLEAR, random_coord(SPREAD_FULL), random_coord(SPREAD_FULL));
                while (na > 0 || nb > 0) begin
                    if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
                        send_item(OP_LOAD_A, random_coord(spread), random_coord(spread));
                        na--;
                    end else begin
                        send_item(OP_LOAD_B, random_coord(spread), random_coord(spread));
                        nb--;
                    end
                end
                send_item(OP_COMPUTE, random_coord(SPREAD_FULL), random_coord(SPREAD_FULL));
                // sometimes grow the sets and compute again
                if ($urandom_range(0, 3) == 0) begin
                    extra = $urandom_range(1, 3);
                    repeat (extra)
                        send_item($urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B,
                                  random_coord(spread), random_coord(spread));
                    send_item(OP_COMPUTE, random_coord(SPREAD_FULL), random_coord(SPREAD_FULL));
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(t_opcode'($urandom_range(0, 3)),
                              random_coord(SPREAD_FULL), random_coord(SPREAD_FULL));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        held_a       = 0;
        held_b       = 0;
        n_items      = 0;
        n_computes   = 0;
        n_results    = 0;
        n_empty      = 0;
        n_dropped    = 0;
        n_errors     = 0;
        burst_left   = 0;
        hold_request = 0;
        hold_left    = 0;
        stall_mode   = 0;
        stall_window = 0;

        item_if.valid   <= 1'b0;
        item_if.opcode  <= OP_LOAD_A;
        item_if.coord_x <= '0;
        item_if.coord_y <= '0;
        i_rst_n         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_sets();
        test_coord_extremes();
        test_ties_and_clear();
        test_set_full(1'b1);
        test_set_full(1'b0);
        test_backpressure();
        test_random_sequences();

        item_if.valid <= 1'b0;
        while (pending_hd.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d computes (%0d on an empty set), %0d loads dropped.",
                 n_items, n_computes, n_empty, n_dropped);
        $display("Checked %0d results, %0d mismatches.", n_results, n_errors);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
